FILE: sv/rpn_stack_evaluator_defines.svh
// ----------------------------------------------------------------------------
// rpn stack evaluator assertion macros
// shared property wrappers, clocked on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define RPN_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// shared types and constants of the rpn stack evaluator
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_DIVZERO   = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// control from the sequencer to the arithmetic unit
	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

FILE: sv/rpn_stack_ram.sv
// ----------------------------------------------------------------------------
// rpn_stack_ram
// operand stack storage, one write and one registered read port
// ----------------------------------------------------------------------------
module rpn_stack_ram #(
	parameter int unsigned DEPTH = rpn_pkg::STACK_DEPTH_DEF,
	parameter int unsigned WIDTH = rpn_pkg::VALUE_WIDTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu
// shared arithmetic unit: add and subtract registered directly, radix-2
// shift-add multiply and restoring divide, one bit per cycle
// ----------------------------------------------------------------------------
`include "rpn_stack_evaluator_defines.svh"

module rpn_alu #(
	parameter int unsigned WIDTH = rpn_pkg::VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rpn_pkg::alu_req_t req,
	input  logic [WIDTH-1:0]  a,
	input  logic [WIDTH-1:0]  b,
	output logic              done,
	output logic [WIDTH-1:0]  result
);

	localparam int unsigned CNTW = $clog2(WIDTH + 1);

	typedef enum logic [1:0] {
		A_IDLE,
		A_RUN,
		A_FIX
	} alu_state_t;

	alu_state_t       state_q;
	rpn_pkg::alu_op_t op_q;
	logic [CNTW-1:0]  cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] rem_q;
	logic             neg_q;
	logic             done_q;
	logic [WIDTH-1:0] result_q;

	logic [WIDTH-1:0] a_mag;
	logic [WIDTH-1:0] b_mag;
	logic [WIDTH:0]   rem_sh;
	logic [WIDTH:0]   rem_diff;

	assign a_mag    = a[WIDTH-1] ? ({WIDTH{1'b0}} - a) : a;
	assign b_mag    = b[WIDTH-1] ? ({WIDTH{1'b0}} - b) : b;
	assign rem_sh   = {rem_q, x_q[WIDTH-1]};
	assign rem_diff = rem_sh - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= A_IDLE;
			op_q     <= rpn_pkg::OP_ADD;
			cnt_q    <= '0;
			acc_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			rem_q    <= '0;
			neg_q    <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			// add and subtract finish at once, multiply and divide after the fix-up
			done_q <= ((state_q == A_IDLE) && req.start
				&& ((req.op == rpn_pkg::OP_ADD) || (req.op == rpn_pkg::OP_SUB)))
				|| (state_q == A_FIX);
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						unique case (req.op)
							rpn_pkg::OP_ADD: begin
								result_q <= a + b;
							end
							rpn_pkg::OP_SUB: begin
								result_q <= a - b;
							end
							rpn_pkg::OP_MUL: begin
								acc_q   <= '0;
								x_q     <= a;
								y_q     <= b;
								cnt_q   <= CNTW'(WIDTH);
								state_q <= A_RUN;
							end
							rpn_pkg::OP_DIV: begin
								rem_q   <= '0;
								x_q     <= a_mag;
								y_q     <= b_mag;
								neg_q   <= a[WIDTH-1] ^ b[WIDTH-1];
								cnt_q   <= CNTW'(WIDTH);
								state_q <= A_RUN;
							end
							default: ;
						endcase
					end
				end
				A_RUN: begin
					if (op_q == rpn_pkg::OP_MUL) begin
						acc_q <= acc_q + (y_q[0] ? x_q : {WIDTH{1'b0}});
						x_q   <= {x_q[WIDTH-2:0], 1'b0};
						y_q   <= {1'b0, y_q[WIDTH-1:1]};
					end else begin
						// restoring step: quotient bits shift in behind the dividend
						if (!rem_diff[WIDTH]) begin
							rem_q <= rem_diff[WIDTH-1:0];
							x_q   <= {x_q[WIDTH-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh[WIDTH-1:0];
							x_q   <= {x_q[WIDTH-2:0], 1'b0};
						end
					end
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					if (op_q == rpn_pkg::OP_MUL) begin
						result_q <= acc_q;
					end else begin
						result_q <= neg_q ? ({WIDTH{1'b0}} - x_q) : x_q;
					end
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`RPN_ASSERT_IMPL(a_alu_start_idle, req.start, state_q == A_IDLE,
		"alu started while busy")
	`RPN_ASSERT_NEXT(a_alu_done_pulse, done_q, !done_q && state_q == A_IDLE,
		"alu done not a single pulse")

endmodule

FILE: sv/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// reverse polish expression evaluator, one character per request
// ----------------------------------------------------------------------------
// usage
//   input channel: ch and end_of_expr with in_valid / in_stall. digits push
//   their value, + - * / pop right then left and push left op right
//   (wrapping, division truncates toward zero), other characters are ignored
//   output channel: value and status with out_valid / out_stall, one request
//   per character marked end_of_expr, after that character is handled
//   steps per request: an ignored character, a digit or an error pass decode
//   and emit, divide by zero adds the read, the other operators the read and
//   the wait on the shared arithmetic unit, longest for multiply and divide by
//   its bit-serial steps; an operator result is on top before ready
//   one request is in work at a time; in_stall is high until it is done
//   a finished result sits in the output register; a new request is still
//   taken while it waits, and only an end character stalls until it leaves
//   reset clears the stack count, the sticky error and the output register;
//   stack storage is not cleared, only written entries are read
// ----------------------------------------------------------------------------
`include "rpn_stack_evaluator_defines.svh"

module rpn_stack_evaluator #(
	parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
	parameter int unsigned VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    ch,
	input  logic                          end_of_expr,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] value,
	output logic [2:0]                    status
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = $clog2(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_ALU,
		S_EMIT
	} seq_state_t;

	seq_state_t                    state_q;
	logic [7:0]                    ch_q;
	logic                          end_q;
	logic [CW-1:0]                 count_q;
	rpn_pkg::status_t              err_q;
	logic [VALUE_WIDTH-1:0]        tos_q;
	rpn_pkg::alu_op_t              op_q;
	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] value_q;
	rpn_pkg::status_t              status_q;

	logic                   in_accept;
	logic                   is_digit;
	logic                   is_op;
	rpn_pkg::alu_op_t       ch_op;
	logic [CW-1:0]          cnt_m1;
	logic [CW-1:0]          cnt_m2;
	logic                   stack_full;
	logic                   mem_wr;
	logic                   mem_rd;
	logic [VALUE_WIDTH-1:0] mem_rdata;
	logic [VALUE_WIDTH-1:0] digit_val;
	logic                   div_zero;
	logic                   out_free;
	logic                   emit_now;
	rpn_pkg::alu_req_t      alu_req;
	logic                   alu_done;
	logic [VALUE_WIDTH-1:0] alu_result;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	// character decode on the captured request
	assign is_digit = (ch_q >= rpn_pkg::CH_ZERO) && (ch_q <= rpn_pkg::CH_NINE);

	always_comb begin
		is_op = 1'b1;
		ch_op = rpn_pkg::OP_ADD;
		unique case (ch_q)
			rpn_pkg::CH_PLUS:  ch_op = rpn_pkg::OP_ADD;
			rpn_pkg::CH_MINUS: ch_op = rpn_pkg::OP_SUB;
			rpn_pkg::CH_STAR:  ch_op = rpn_pkg::OP_MUL;
			rpn_pkg::CH_SLASH: ch_op = rpn_pkg::OP_DIV;
			default:           is_op = 1'b0;
		endcase
	end

	assign digit_val  = {{(VALUE_WIDTH - 4){1'b0}}, 4'(ch_q - rpn_pkg::CH_ZERO)};
	assign cnt_m1     = count_q - CW'(1);
	assign cnt_m2     = count_q - CW'(2);
	assign stack_full = (count_q >= CW'(STACK_DEPTH));

	// the top entry lives in tos_q; the memory holds the entries below it
	assign mem_wr = (state_q == S_DECODE) && (err_q == rpn_pkg::ST_OK) && is_digit
		&& !stack_full && (count_q != '0);
	assign mem_rd = (state_q == S_DECODE) && (err_q == rpn_pkg::ST_OK) && is_op
		&& (count_q >= CW'(2));

	assign div_zero      = (op_q == rpn_pkg::OP_DIV) && (tos_q == '0);
	assign alu_req.start = (state_q == S_READ) && !div_zero;
	assign alu_req.op    = op_q;

	// output register free this cycle, either empty or being taken
	assign out_free = !out_valid_q || !out_stall;
	// end request loads the output register this cycle
	assign emit_now = (state_q == S_EMIT) && end_q && out_free;

	rpn_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (VALUE_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (cnt_m1[AW-1:0]),
		.wr_data (tos_q),
		.rd_en   (mem_rd),
		.rd_addr (cnt_m2[AW-1:0]),
		.rd_data (mem_rdata)
	);

	rpn_alu #(
		.WIDTH (VALUE_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (mem_rdata),
		.b      (tos_q),
		.done   (alu_done),
		.result (alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			end_q       <= 1'b0;
			count_q     <= '0;
			err_q       <= rpn_pkg::ST_OK;
			tos_q       <= '0;
			op_q        <= rpn_pkg::OP_ADD;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			status_q    <= rpn_pkg::ST_OK;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						ch_q    <= ch;
						end_q   <= end_of_expr;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					// an operator with two entries goes on to read the left one
					if (mem_rd) begin
						op_q    <= ch_op;
						state_q <= S_READ;
					end else begin
						state_q <= S_EMIT;
					end
					// sticky error: ignore everything until the end request
					if (err_q == rpn_pkg::ST_OK) begin
						if (is_digit) begin
							if (stack_full) begin
								err_q <= rpn_pkg::ST_OVERFLOW;
							end else begin
								tos_q   <= digit_val;
								count_q <= count_q + CW'(1);
							end
						end else if (is_op && (count_q < CW'(2))) begin
							err_q <= rpn_pkg::ST_UNDERFLOW;
						end
					end
				end
				S_READ: begin
					// left operand now out of the memory
					if (div_zero) begin
						err_q   <= rpn_pkg::ST_DIVZERO;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_ALU;
					end
				end
				S_ALU: begin
					if (alu_done) begin
						tos_q   <= alu_result;
						count_q <= cnt_m1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!end_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						if (err_q != rpn_pkg::ST_OK) begin
							value_q  <= '0;
							status_q <= err_q;
						end else if (count_q == '0) begin
							value_q  <= '0;
							status_q <= rpn_pkg::ST_EMPTY;
						end else begin
							value_q  <= tos_q;
							status_q <= rpn_pkg::ST_OK;
						end
						count_q <= '0;
						err_q   <= rpn_pkg::ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	`RPN_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(STACK_DEPTH),
		"stack count beyond depth")
	`RPN_ASSERT_IMPL(a_alu_done_state, alu_done, state_q == S_ALU,
		"alu result arrived outside the wait state")
	`RPN_ASSERT_NEXT(a_accept_decode, in_accept, state_q == S_DECODE,
		"accepted request not decoded next cycle")

endmodule

FILE: tb/sv/rpn_expr_checker.sv
// ----------------------------------------------------------------------------
// rpn_expr_checker
// watches both channels of the rpn stack evaluator, keeps its own operand
// stack and sticky error, and compares every result with the expected one
// ----------------------------------------------------------------------------
module rpn_expr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        end_of_expr,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] value,
	input  logic [2:0]  status,
	output int          fail_count,
	output int          pending
);

	localparam int unsigned DEPTH = rpn_pkg::STACK_DEPTH_DEF;

	typedef struct packed {
		logic [31:0]      value;
		rpn_pkg::status_t status;
	} expr_result_t;

	logic [31:0]      operand_mem [DEPTH];
	int unsigned      depth_used = 0;
	rpn_pkg::status_t first_error = rpn_pkg::ST_OK;
	expr_result_t     expected_results [$];
	int               fails = 0;

	function automatic void apply_char(input logic [7:0] c);
		logic [31:0] rhs;
		logic [31:0] lhs;
		logic [31:0] mag_l;
		logic [31:0] mag_r;
		logic [31:0] res;
		if (first_error != rpn_pkg::ST_OK)
			return;
		if (c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE) begin
			if (depth_used >= DEPTH) begin
				first_error = rpn_pkg::ST_OVERFLOW;
				return;
			end
			operand_mem[depth_used] = {24'd0, c - rpn_pkg::CH_ZERO};
			depth_used++;
			return;
		end
		if (c != rpn_pkg::CH_PLUS && c != rpn_pkg::CH_MINUS && c != rpn_pkg::CH_STAR
			&& c != rpn_pkg::CH_SLASH)
			return;
		if (depth_used < 2) begin
			first_error = rpn_pkg::ST_UNDERFLOW;
			return;
		end
		rhs = operand_mem[depth_used - 1];
		lhs = operand_mem[depth_used - 2];
		case (c)
			rpn_pkg::CH_PLUS:  res = lhs + rhs;
			rpn_pkg::CH_MINUS: res = lhs - rhs;
			rpn_pkg::CH_STAR:  res = lhs * rhs;
			default: begin
				if (rhs == '0) begin
					first_error = rpn_pkg::ST_DIVZERO;
					return;
				end
				// unsigned divide of magnitudes, so min / -1 just wraps
				mag_l = lhs[31] ? -lhs : lhs;
				mag_r = rhs[31] ? -rhs : rhs;
				res = mag_l / mag_r;
				if (lhs[31] ^ rhs[31])
					res = -res;
			end
		endcase
		depth_used--;
		operand_mem[depth_used - 1] = res;
	endfunction

	always @(posedge clk) begin
		expr_result_t want;
		if (!arst_n) begin
			depth_used = 0;
			first_error = rpn_pkg::ST_OK;
			expected_results.delete();
		end else begin
			if (in_valid && !in_stall) begin
				apply_char(ch);
				if (end_of_expr) begin
					want.value = '0;
					if (first_error != rpn_pkg::ST_OK) begin
						want.status = first_error;
					end else if (depth_used == 0) begin
						want.status = rpn_pkg::ST_EMPTY;
					end else begin
						want.status = rpn_pkg::ST_OK;
						want.value = operand_mem[depth_used - 1];
					end
					expected_results.push_back(want);
					depth_used = 0;
					first_error = rpn_pkg::ST_OK;
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: value %0d status %0d",
						$signed(value), status);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (value !== want.value) begin
						$error("value mismatch: expected %0d, actual %0d",
							$signed(want.value), $signed(value));
						fails++;
					end
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, status);
						fails++;
					end
				end
			end
		end
		fail_count <= fails;
		pending <= expected_results.size();
	end

endmodule

FILE: tb/sv/tb_rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// tb_rpn_stack_evaluator
// drives expressions into the rpn stack evaluator one character per request,
// short directed expressions first, then random ones in three idle phases;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_rpn_stack_evaluator;

	localparam int unsigned DEPTH        = rpn_pkg::STACK_DEPTH_DEF;
	localparam int          ITEM_GOAL    = 1450;
	localparam int          CYCLE_LIMIT  = 1_000_000;
	localparam int          HOLD_CYCLES  = 400;
	// give the tail of the run some slack
	localparam int          DRAIN_CYCLES = 60;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         ch;
	logic               end_of_expr;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] value;
	logic [2:0]         status;

	int fail_count;
	int pending;

	// idle rates and the long output hold-off
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int hold_requests = 0;
	int holds_taken   = 0;
	int hold_left     = 0;

	// accepted requests of every kind
	int work_items  = 0;
	int cycle_count = 0;

	logic [7:0] expr_buf [$];

	rpn_stack_evaluator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ch          (ch),
		.end_of_expr (end_of_expr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.status      (status)
	);

	rpn_expr_checker expr_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ch          (ch),
		.end_of_expr (end_of_expr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.status      (status),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, ends a hung run with the fail verdict
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// output side: random stall, or a long hold-off when one is requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (holds_taken != hold_requests) begin
				holds_taken++;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	function automatic logic [7:0] digit(input int unsigned n);
		return rpn_pkg::CH_ZERO + 8'(n);
	endfunction

	// true for characters the block acts on
	function automatic logic acts(input logic [7:0] c);
		return (c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE) || c == rpn_pkg::CH_PLUS
			|| c == rpn_pkg::CH_MINUS || c == rpn_pkg::CH_STAR || c == rpn_pkg::CH_SLASH;
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(3))
			0:       return rpn_pkg::CH_PLUS;
			1:       return rpn_pkg::CH_MINUS;
			2:       return rpn_pkg::CH_STAR;
			default: return rpn_pkg::CH_SLASH;
		endcase
	endfunction

	function automatic logic [7:0] ignored_char();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		while (acts(c))
			c = 8'($urandom_range(255));
		return c;
	endfunction

	// one request; valid stays high into the next call unless it idles
	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		end_of_expr <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		work_items++;
	endtask

	// the last character of the buffer carries the end mark
	task automatic send_expr();
		for (int i = 0; i < expr_buf.size(); i++)
			send_char(expr_buf[i], i == expr_buf.size() - 1);
	endtask

	// sender stops until every expected result is back
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic make_random_expr();
		int kind;
		int operands;
		int depth;
		int n;
		expr_buf.delete();
		kind = $urandom_range(99);
		if (kind < 65) begin
			// well-formed expression, a few ignored characters mixed in
			operands = ($urandom_range(9) == 0) ? $urandom_range(9, 20)
				: $urandom_range(1, 8);
			depth = 0;
			while (operands > 0 || depth > 1) begin
				if ($urandom_range(9) == 0)
					expr_buf.push_back(ignored_char());
				if (depth < 2 || (operands > 0 && $urandom_range(1) == 0)) begin
					expr_buf.push_back(digit($urandom_range(9)));
					operands--;
					depth++;
				end else begin
					expr_buf.push_back(pick_op());
					depth--;
				end
			end
		end else if (kind < 72) begin
			// long product chain, the longer ones wrap past the 32-bit range
			expr_buf.push_back(digit(9));
			n = $urandom_range(5, 15);
			repeat (n) begin
				expr_buf.push_back(digit($urandom_range(7, 9)));
				expr_buf.push_back(rpn_pkg::CH_STAR);
			end
			if ($urandom_range(1)) begin
				expr_buf.push_back(digit($urandom_range(9)));
				expr_buf.push_back(pick_op());
			end
		end else if (kind < 76) begin
			// 8^10 * 2 lands on the most negative value, then apply -1
			expr_buf.push_back(digit(8));
			repeat (9) begin
				expr_buf.push_back(digit(8));
				expr_buf.push_back(rpn_pkg::CH_STAR);
			end
			expr_buf.push_back(digit(2));
			expr_buf.push_back(rpn_pkg::CH_STAR);
			expr_buf.push_back(digit(0));
			expr_buf.push_back(digit(1));
			expr_buf.push_back(rpn_pkg::CH_MINUS);
			expr_buf.push_back($urandom_range(1) ? rpn_pkg::CH_SLASH : rpn_pkg::CH_STAR);
		end else if (kind < 80) begin
			// fill the stack to near its depth, sometimes past it
			n = $urandom_range(DEPTH - 2, DEPTH + 3);
			repeat (n)
				expr_buf.push_back(digit($urandom_range(9)));
			repeat ($urandom_range(n))
				expr_buf.push_back(pick_op());
		end else if (kind < 90) begin
			// broken sequence, leans to underflow and divide by zero
			repeat ($urandom_range(1, 10))
				expr_buf.push_back($urandom_range(1) ? pick_op() : digit($urandom_range(2)));
		end else begin
			// raw noise over the whole character range
			repeat ($urandom_range(0, 5))
				expr_buf.push_back(8'($urandom_range(255)));
		end
		// end mark now and then on an ignored character
		if ($urandom_range(4) == 0 || expr_buf.size() == 0)
			expr_buf.push_back(ignored_char());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = 8'd0;
		end_of_expr = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored extremes around a plain sum
		expr_buf = {8'h00, digit(9), digit(0), rpn_pkg::CH_PLUS, 8'hff};
		send_expr();
		// operator on an empty stack
		expr_buf = {rpn_pkg::CH_PLUS};
		send_expr();
		// divide by zero
		expr_buf = {digit(5), digit(0), rpn_pkg::CH_SLASH};
		send_expr();
		// negative difference times three
		expr_buf = {digit(2), digit(9), rpn_pkg::CH_MINUS, digit(3), rpn_pkg::CH_STAR};
		send_expr();
		// negative quotient truncates toward zero
		expr_buf = {digit(0), digit(7), rpn_pkg::CH_MINUS, digit(2), rpn_pkg::CH_SLASH};
		send_expr();
		// nothing pushed, high character bit set
		expr_buf = {8'h80};
		send_expr();
		// two entries left, top one reported
		expr_buf = {digit(1), digit(2)};
		send_expr();
		// underflow sticks and masks the later digit
		expr_buf = {digit(3), rpn_pkg::CH_PLUS, digit(4)};
		send_expr();
		pause_until_drained();

		// random part in three idle phases, drained between them
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 9;
					rx_idle_pct <= 87;
				end
				1: begin
					tx_idle_pct = 87;
					rx_idle_pct <= 9;
				end
				default: begin
					// no idling, and one long hold-off to back the block up
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
					hold_requests <= hold_requests + 1;
				end
			endcase
			while (work_items < ITEM_GOAL * (phase + 1) / 3) begin
				make_random_expr();
				send_expr();
			end
			pause_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
